FILE: hdl/mwg_pkg.sv
`timescale 1ns / 1ps

package mwg_pkg;

	// Output sample range: saturate to +/-(2^(SAMPLE_BITS-1) - 1), then keep 16 bits.
	localparam int unsigned SAMPLE_BITS = 16;
	localparam int unsigned SAT_LIM = (1 << (SAMPLE_BITS - 1)) - 1;

	// pi/2 in Q30, used to build the sine table at elaboration and the testbench's copy.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Queue depths as log2 of the entry count.
	localparam int MID_AW = 2;
	localparam int OUT_AW = 2;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_TRIANGLE = 2'd2,
		WAVE_SAWTOOTH = 2'd3
	} wave_t;

	typedef enum logic [1:0] {
		REG_WAVE_SELECT  = 2'd0,
		REG_PHASE_STEP   = 2'd1,
		REG_PHASE_OFFSET = 2'd2,
		REG_AMPLITUDE    = 2'd3
	} reg_idx_t;

	// One classified sample command handed from the front end to the back end.
	typedef struct packed {
		logic        is_sine;
		logic        neg;
		logic        start;
		logic [15:0] lin_mag;
	} cmd_t;

	// Quarter-wave sine entry k of a table with 2^abits steps, Q1.15, capped at one.
	// Evaluated only at elaboration with Taylor terms up to x^15 in Q30.
	function automatic logic [15:0] sine_q15(input logic [31:0] k, input int unsigned abits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        mag;
		logic signed [63:0] sum;
		x   = (64'(k) * HALF_PI_Q30) >> abits;
		x2  = (x * x) >> 30;
		mag = x;
		sum = $signed(x);
		mag = ((mag * x2) >> 30) / 64'd6;
		sum = sum - $signed(mag);
		mag = ((mag * x2) >> 30) / 64'd20;
		sum = sum + $signed(mag);
		mag = ((mag * x2) >> 30) / 64'd42;
		sum = sum - $signed(mag);
		mag = ((mag * x2) >> 30) / 64'd72;
		sum = sum + $signed(mag);
		mag = ((mag * x2) >> 30) / 64'd110;
		sum = sum - $signed(mag);
		mag = ((mag * x2) >> 30) / 64'd156;
		sum = sum + $signed(mag);
		mag = ((mag * x2) >> 30) / 64'd210;
		sum = sum - $signed(mag);
		if (sum < 0) begin
			sum = '0;
		end
		sum = (sum + 64'sd16384) >>> 15;
		if (sum > 64'sd32768) begin
			sum = 64'sd32768;
		end
		return sum[15:0];
	endfunction

endpackage

FILE: hdl/mwg_fifo.sv
`timescale 1ns / 1ps

module mwg_fifo #(
	parameter int WIDTH = 8,
	parameter int AW    = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty,
	output logic [AW:0]      count
);

	localparam int DEPTH = 1 << AW;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: hdl/mwg_front.sv
`timescale 1ns / 1ps

module mwg_front #(
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic                     restart,
	input  mwg_pkg::wave_t           wave_select,
	input  logic [31:0]              phase_step,
	input  logic [31:0]              phase_offset,
	output mwg_pkg::cmd_t            cmd,
	output logic [TABLE_ADDR_BITS:0] rom_idx
);

	localparam logic [TABLE_ADDR_BITS:0] QTAB_N_IDX = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

	logic [PHASE_BITS-1:0]    acc_q;
	logic                     carry_q;
	logic [PHASE_BITS-1:0]    acc_base;
	logic                     carry_base;
	logic [PHASE_BITS:0]      acc_next;
	logic [PHASE_BITS-1:0]    phase;
	logic [PHASE_BITS+16:0]   phase_pad;
	logic [16:0]              tri_pos;
	logic [15:0]              saw_pos;
	logic [TABLE_ADDR_BITS-1:0] quad_k;
	logic signed [17:0]       unit;
	logic signed [17:0]       unit_abs;

	// Restart acts before this item, so the item itself sees a cleared accumulator.
	assign acc_base   = restart ? '0 : acc_q;
	assign carry_base = restart ? 1'b0 : carry_q;
	assign acc_next   = {1'b0, acc_base} + {1'b0, PHASE_BITS'(phase_step)};
	assign phase      = acc_base + PHASE_BITS'(phase_offset);

	// Padding below the phase lets the top 17 or 16 bits be taken at any phase width.
	assign phase_pad = {phase, 17'b0};
	assign tri_pos   = phase_pad[PHASE_BITS+16 -: 17];
	assign saw_pos   = phase_pad[PHASE_BITS+16 -: 16];
	assign quad_k    = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];

	always_comb begin
		case (wave_select)
			mwg_pkg::WAVE_SQUARE: begin
				unit = phase[PHASE_BITS-1] ? -18'sd32768 : 18'sd32768;
			end
			mwg_pkg::WAVE_TRIANGLE: begin
				unit = tri_pos[16] ? (18'sd98304 - $signed({1'b0, tri_pos}))
				                   : ($signed({1'b0, tri_pos}) - 18'sd32768);
			end
			mwg_pkg::WAVE_SAWTOOTH: begin
				unit = $signed({2'b0, saw_pos}) - 18'sd32768;
			end
			default: begin
				unit = '0;
			end
		endcase
	end

	assign unit_abs = unit[17] ? -unit : unit;

	always_comb begin
		cmd.is_sine = (wave_select == mwg_pkg::WAVE_SINE);
		cmd.neg     = cmd.is_sine ? phase[PHASE_BITS-1] : unit[17];
		cmd.start   = (acc_base == '0) || carry_base;
		cmd.lin_mag = unit_abs[15:0];
	end

	// Odd quadrants walk the quarter table backward.
	assign rom_idx = phase[PHASE_BITS-2] ? (QTAB_N_IDX - {1'b0, quad_k}) : {1'b0, quad_k};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			carry_q <= 1'b0;
		end else if (accept) begin
			acc_q   <= acc_next[PHASE_BITS-1:0];
			carry_q <= acc_next[PHASE_BITS];
		end
	end

endmodule

FILE: hdl/mwg_back.sv
`timescale 1ns / 1ps

module mwg_back #(
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  mwg_pkg::cmd_t              cmd,
	input  logic [TABLE_ADDR_BITS:0]   rom_idx,
	input  logic [14:0]                amplitude,
	input  logic [mwg_pkg::OUT_AW:0]   out_count,
	output logic                       cmd_pop,
	output logic                       out_wr,
	output logic [15:0]                out_sample,
	output logic                       out_start
);

	localparam int unsigned QTAB_N = 1 << TABLE_ADDR_BITS;
	localparam int CW = mwg_pkg::OUT_AW + 2;

	typedef logic [15:0] qtab_t [0:QTAB_N];

	function automatic qtab_t build_qtab();
		qtab_t tab;
		for (int i = 0; i <= int'(QTAB_N); i++) begin
			tab[i] = mwg_pkg::sine_q15(32'(i), TABLE_ADDR_BITS);
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	logic          valid_s1;
	logic [15:0]   rom_s1;
	logic [15:0]   lin_s1;
	logic          sine_s1;
	logic          neg_s1;
	logic          start_s1;
	logic          valid_s2;
	logic [30:0]   prod_s2;
	logic          neg_s2;
	logic          start_s2;
	logic [CW-1:0] in_flight;
	logic [15:0]   scaled;
	logic [15:0]   sat_mag;

	// Every popped command has a reserved slot in the output queue, so the
	// pipeline never has to stall.
	assign in_flight = CW'(out_count) + CW'(valid_s1) + CW'(valid_s2);
	assign cmd_pop   = cmd_valid && (in_flight < CW'(1 << mwg_pkg::OUT_AW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd_pop;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		rom_s1   <= QTAB[rom_idx];
		lin_s1   <= cmd.lin_mag;
		sine_s1  <= cmd.is_sine;
		neg_s1   <= cmd.neg;
		start_s1 <= cmd.start;
		prod_s2  <= 31'(sine_s1 ? rom_s1 : lin_s1) * 31'(amplitude);
		neg_s2   <= neg_s1;
		start_s2 <= start_s1;
	end

	assign scaled     = prod_s2[30:15];
	assign sat_mag    = (32'(scaled) > mwg_pkg::SAT_LIM) ? 16'(mwg_pkg::SAT_LIM) : scaled;
	assign out_sample = neg_s2 ? (16'd0 - sat_mag) : sat_mag;
	assign out_start  = start_s2;
	assign out_wr     = valid_s2;

endmodule

FILE: hdl/multi_waveform_generator.sv
// Each result passes the command queue, the table and scaling stages and the result queue.
// Throughput: one item per cycle while the command queue and the result queue have room.
// The sine quarter table is a registered ROM read in the first back-end stage.
// Reset (arst_n low, asynchronous) clears the phase, the carry, all queues and the pipeline
// valids, and loads the register defaults: sine, 1/50 turn step, zero offset, full amplitude.
`timescale 1ns / 1ps

module multi_waveform_generator #(
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// Item input queue side.
	input  logic        push,
	output logic        full,
	input  logic        restart,
	// Result queue side.
	output logic        empty,
	input  logic        pop,
	output logic [15:0] sample,
	output logic        period_start,
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int MID_W = $bits(mwg_pkg::cmd_t) + TABLE_ADDR_BITS + 1;

	// Configuration registers.
	mwg_pkg::wave_t wave_select_q;
	logic [31:0]    phase_step_q;
	logic [31:0]    phase_offset_q;
	logic [14:0]    amplitude_q;

	logic                         cfg_wr;
	mwg_pkg::reg_idx_t            cfg_idx;
	logic                         in_accept;
	mwg_pkg::cmd_t                front_cmd;
	logic [TABLE_ADDR_BITS:0]     front_idx;
	logic                         mid_full;
	logic                         mid_empty;
	logic                         mid_pop;
	logic [MID_W-1:0]             mid_rd;
	logic [mwg_pkg::MID_AW:0]     mid_count;
	mwg_pkg::cmd_t                back_cmd;
	logic [TABLE_ADDR_BITS:0]     back_idx;
	logic                         out_wr;
	logic [15:0]                  out_sample;
	logic                         out_start;
	logic                         out_full;
	logic [mwg_pkg::OUT_AW:0]     out_count;

	// Registers sit on word addresses; the two low address bits are not decoded.
	assign pready  = 1'b1;
	assign cfg_idx = mwg_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_select_q  <= mwg_pkg::WAVE_SINE;
			phase_step_q   <= 32'd85899346;
			phase_offset_q <= '0;
			amplitude_q    <= 15'd32767;
		end else if (cfg_wr) begin
			case (cfg_idx)
				mwg_pkg::REG_WAVE_SELECT: begin
					wave_select_q <= mwg_pkg::wave_t'(pwdata[1:0]);
				end
				mwg_pkg::REG_PHASE_STEP: begin
					phase_step_q <= pwdata;
				end
				mwg_pkg::REG_PHASE_OFFSET: begin
					phase_offset_q <= pwdata;
				end
				mwg_pkg::REG_AMPLITUDE: begin
					amplitude_q <= pwdata[14:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			mwg_pkg::REG_WAVE_SELECT:  prdata = {30'b0, wave_select_q};
			mwg_pkg::REG_PHASE_STEP:   prdata = phase_step_q;
			mwg_pkg::REG_PHASE_OFFSET: prdata = phase_offset_q;
			mwg_pkg::REG_AMPLITUDE:    prdata = {17'b0, amplitude_q};
			default:                   prdata = '0;
		endcase
	end

	// The front end advances the phase and classifies each item as soon as it
	// arrives; it only waits when the command queue is full.
	assign full      = mid_full;
	assign in_accept = push && !mid_full;

	mwg_front #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_accept),
		.restart      (restart),
		.wave_select  (wave_select_q),
		.phase_step   (phase_step_q),
		.phase_offset (phase_offset_q),
		.cmd          (front_cmd),
		.rom_idx      (front_idx)
	);

	// Command queue between the front and back ends.
	mwg_fifo #(
		.WIDTH (MID_W),
		.AW    (mwg_pkg::MID_AW)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_accept),
		.wr_data ({front_cmd, front_idx}),
		.rd_en   (mid_pop),
		.rd_data (mid_rd),
		.full    (mid_full),
		.empty   (mid_empty),
		.count   (mid_count)
	);

	assign back_cmd = mid_rd[MID_W-1 -: $bits(mwg_pkg::cmd_t)];
	assign back_idx = mid_rd[TABLE_ADDR_BITS:0];

	// The back end looks up the sine table, scales by the amplitude and
	// saturates. It takes a command only when the result queue has room for it.
	mwg_back #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (!mid_empty),
		.cmd        (back_cmd),
		.rom_idx    (back_idx),
		.amplitude  (amplitude_q),
		.out_count  (out_count),
		.cmd_pop    (mid_pop),
		.out_wr     (out_wr),
		.out_sample (out_sample),
		.out_start  (out_start)
	);

	// Result queue; the oldest result is shown on the output ports.
	mwg_fifo #(
		.WIDTH (17),
		.AW    (mwg_pkg::OUT_AW)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data ({out_sample, out_start}),
		.rd_en   (pop),
		.rd_data ({sample, period_start}),
		.full    (out_full),
		.empty   (empty),
		.count   (out_count)
	);

	// The back end reserves a result slot before it takes a command, so a
	// result never arrives at a full result queue.
	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> !out_full)
		else $error("result written into a full result queue");

	// The back end never takes a command that is not there.
	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("command popped from an empty queue");

	// An item that was accepted into an empty command queue is visible to the
	// back end in the next cycle.
	a_mid_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && mid_empty && !mid_pop) |=> (!mid_empty && mid_count != '0))
		else $error("accepted item did not reach the command queue");

	// Saturation keeps the most negative code off the output.
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (sample != 16'h8000))
		else $error("sample left the saturated range");

endmodule

FILE: dv/multi_waveform_generator_tb.sv
`timescale 1ns / 1ps

module multi_waveform_generator_tb;

	// PIPE_LATENCY is the delay from a taken item to its result; drain() waits it out after
	// the last result so that the pipeline goes quiet.
	localparam int PIPE_LATENCY = 3;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 700;
	localparam int LONG_HOLD    = 300;
	localparam int QTAB_N       = 1024;

	// Ways the result side takes samples, switched every so often.
	typedef enum logic [1:0] {
		RX_STREAM  = 2'd0,
		RX_RANDOM  = 2'd1,
		RX_PATTERN = 2'd2,
		RX_SLOW    = 2'd3
	} rx_mode_t;

	typedef struct {
		logic [15:0] sample;
		logic        period_start;
	} wave_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        restart = 1'b0;
	logic        pop = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic        full;
	logic        empty;
	logic [15:0] sample;
	logic        period_start;
	logic [31:0] prdata;
	logic        pready;

	multi_waveform_generator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.restart      (restart),
		.empty        (empty),
		.pop          (pop),
		.sample       (sample),
		.period_start (period_start),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Our own copy of the quarter-wave sine table, the register settings and the phase.
	int             sine_rom [0:QTAB_N];
	mwg_pkg::wave_t cfg_wave = mwg_pkg::WAVE_SINE;
	logic [31:0]    cfg_step = 32'd85899346;
	logic [31:0]    cfg_offset = '0;
	logic [14:0]    cfg_amp = 15'h7FFF;
	logic [31:0]    phase_acc = '0;
	logic           phase_carry = 1'b0;

	// Items waiting to be offered (only the restart flag travels with an item), and the
	// samples predicted for items already taken, oldest first.
	logic         restart_q [$];
	wave_result_t pending_samples [$];

	int       fails = 0;
	int       cycles = 0;
	int       hold_req = 0;
	int       hold_seen = 0;
	int       hold_left = 0;
	int       rx_cycle = 0;
	rx_mode_t rx_mode = RX_STREAM;
	int       burst_left = 1;
	int       gap_left = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// Table entry k holds round(32768 * sin(pi/2 * k / 1024)) from Q30 Taylor terms
	// up to x^15, clamped to one.
	function automatic int quarter_sine(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		int              n;
		x = (64'(k) * mwg_pkg::HALF_PI_Q30) / QTAB_N;
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		acc = (acc + 16384) >>> 15;
		if (acc > 32768) begin
			acc = 32768;
		end
		return int'(acc);
	endfunction

	// Works out the sample for one item and advances the phase accumulator.
	function automatic wave_result_t next_sample(input logic rst);
		wave_result_t r;
		logic [31:0]  p;
		logic [32:0]  sum;
		logic [16:0]  ramp_pos;
		int unsigned  idx;
		int           u;
		int           mag;
		if (rst) begin
			phase_acc = '0;
			phase_carry = 1'b0;
		end
		r.period_start = (phase_acc == 32'd0) || phase_carry;
		p = phase_acc + cfg_offset;
		case (cfg_wave)
			mwg_pkg::WAVE_SINE: begin
				// Odd quadrants read the table backward, the second half turn is negated.
				idx = p[30] ? QTAB_N - p[29:20] : p[29:20];
				u = p[31] ? -sine_rom[idx] : sine_rom[idx];
			end
			mwg_pkg::WAVE_SQUARE: begin
				u = p[31] ? -32768 : 32768;
			end
			mwg_pkg::WAVE_TRIANGLE: begin
				ramp_pos = p[31:15];
				u = (ramp_pos < 17'd65536) ? int'(ramp_pos) - 32768 : 98304 - int'(ramp_pos);
			end
			default: begin
				u = int'(p[31:16]) - 32768;
			end
		endcase
		// Scale the magnitude, truncating toward zero, then put the sign back.
		mag = ((u < 0 ? -u : u) * int'(cfg_amp)) >>> 15;
		if (mag > int'(mwg_pkg::SAT_LIM)) begin
			mag = int'(mwg_pkg::SAT_LIM);
		end
		r.sample = (u < 0) ? 16'(-mag) : 16'(mag);
		sum = {1'b0, phase_acc} + {1'b0, cfg_step};
		phase_carry = sum[32];
		phase_acc = sum[31:0];
		return r;
	endfunction

	// Register write in a setup and an access cycle, then the same register is read
	// back and compared with what it should hold after masking.
	task automatic write_reg(input mwg_pkg::reg_idx_t idx, input logic [31:0] value);
		logic [31:0] kept;
		case (idx)
			mwg_pkg::REG_WAVE_SELECT:  kept = {30'd0, value[1:0]};
			mwg_pkg::REG_PHASE_STEP:   kept = value;
			mwg_pkg::REG_PHASE_OFFSET: kept = value;
			default:                   kept = {17'd0, value[14:0]};
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// The register takes the value at this edge; psel stays up for the read.
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			mwg_pkg::REG_WAVE_SELECT:  cfg_wave = mwg_pkg::wave_t'(kept[1:0]);
			mwg_pkg::REG_PHASE_STEP:   cfg_step = kept;
			mwg_pkg::REG_PHASE_OFFSET: cfg_offset = kept;
			default:                   cfg_amp = kept[14:0];
		endcase
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== kept) begin
			$error("%s readback: expected %h, actual %h", idx.name(), kept, prdata);
			fails++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Waits until every queued item has been taken and every predicted sample has come
	// out, then lets the pipeline settle.
	task automatic drain();
		while (restart_q.size() != 0 || push || pending_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// New settings for a random phase, leaning toward the extremes. Upper bits of the
	// narrow registers are filled with noise so that the masking gets exercised.
	task automatic pick_settings(input bit write_all);
		logic [31:0] value;
		if (write_all || $urandom_range(0, 1) == 1) begin
			write_reg(mwg_pkg::REG_WAVE_SELECT, $urandom);
		end
		if (write_all || $urandom_range(0, 1) == 1) begin
			case ($urandom_range(0, 5))
				0:       value = 32'd0;
				1:       value = 32'hFFFF_FFFF;
				2:       value = $urandom_range(1, 1 << 20);
				3:       value = 32'h8000_0000;
				default: value = $urandom;
			endcase
			write_reg(mwg_pkg::REG_PHASE_STEP, value);
		end
		if (write_all || $urandom_range(0, 1) == 1) begin
			case ($urandom_range(0, 3))
				0:       value = 32'd0;
				1:       value = 32'hFFFF_FFFF;
				default: value = $urandom;
			endcase
			write_reg(mwg_pkg::REG_PHASE_OFFSET, value);
		end
		if (write_all || $urandom_range(0, 1) == 1) begin
			value = $urandom;
			case ($urandom_range(0, 3))
				0:       value[14:0] = 15'd0;
				1:       value[14:0] = 15'h7FFF;
				default: ;
			endcase
			write_reg(mwg_pkg::REG_AMPLITUDE, value);
		end
	endtask

	// Sender: offers the head of restart_q in bursts of random length, with random gaps
	// between bursts. A burst counts items actually taken by the block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				void'(restart_q.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (restart_q.size() != 0) begin
				push <= 1'b1;
				restart <= restart_q[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Every item the block takes gets its sample predicted right away.
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			pending_samples.push_back(next_sample(restart));
		end
	end

	// Receiver: its own stall pattern, plus a long hold-off whenever the stimulus asks for one.
	// The hold is counted here, cycle by cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (rx_cycle % 50 == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (rx_mode)
					RX_STREAM:  pop <= 1'b1;
					RX_RANDOM:  pop <= ($urandom_range(0, 1) == 1);
					RX_PATTERN: pop <= (rx_cycle % 3 != 0);
					default:    pop <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Each sample taken from the block is checked against the oldest prediction.
	always @(posedge clk) begin : result_check
		wave_result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_samples.size() == 0) begin
				$error("unexpected sample: sample=%0d period_start=%0b",
					$signed(sample), period_start);
				fails++;
			end else begin
				want = pending_samples.pop_front();
				if (sample !== want.sample) begin
					$error("sample: expected %0d, actual %0d",
						$signed(want.sample), $signed(sample));
					fails++;
				end
				if (period_start !== want.period_start) begin
					$error("period_start: expected %0b, actual %0b",
						want.period_start, period_start);
					fails++;
				end
			end
		end
	end

	// Watchdog: far more cycles than the slowest correct run needs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("multi_waveform_generator test failed");
			$finish;
		end
	end

	initial begin
		int i;
		int n_items;
		int n_random;
		int phase_no;
		for (i = 0; i <= QTAB_N; i++) begin
			sine_rom[i] = quarter_sine(i);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: sine at a fiftieth of a turn. The first sample sees a zero
		// accumulator, and a restart in the middle starts the period over.
		restart_q.push_back(1'b0);
		restart_q.push_back(1'b0);
		restart_q.push_back(1'b0);
		restart_q.push_back(1'b1);
		restart_q.push_back(1'b0);
		drain();

		// Each waveform at a quarter turn per sample, so that the four quadrants are hit
		// exactly, including both ends of the sine table and the square's sign change.
		write_reg(mwg_pkg::REG_PHASE_STEP, 32'h4000_0000);
		for (i = 0; i < 4; i++) begin
			write_reg(mwg_pkg::REG_WAVE_SELECT, ($urandom & 32'hFFFF_FFFC) | i);
			restart_q.push_back(1'b1);
			restart_q.push_back(1'b0);
			restart_q.push_back(1'b0);
			restart_q.push_back(1'b0);
			drain();
		end

		// Largest step and offset with zero amplitude: the step wraps nearly every
		// sample, so the carry marks the period starts.
		write_reg(mwg_pkg::REG_WAVE_SELECT, {30'd0, mwg_pkg::WAVE_SAWTOOTH});
		write_reg(mwg_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(mwg_pkg::REG_PHASE_OFFSET, 32'hFFFF_FFFF);
		write_reg(mwg_pkg::REG_AMPLITUDE, 32'hFFFF_8000);
		restart_q.push_back(1'b0);
		restart_q.push_back(1'b0);
		restart_q.push_back(1'b0);
		drain();

		// Full amplitude with a frozen phase.
		write_reg(mwg_pkg::REG_AMPLITUDE, 32'h0000_7FFF);
		write_reg(mwg_pkg::REG_PHASE_STEP, 32'd0);
		restart_q.push_back(1'b0);
		restart_q.push_back(1'b0);
		drain();

		// Random phases: new settings, then long runs of items where restart is rare, so
		// the accumulator travels through many periods. One phase has the receiver hold
		// off long enough for the block to fill up and push back on the sender.
		phase_no = 0;
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			pick_settings(phase_no == 0);
			n_items = (phase_no == 2) ? 80 : $urandom_range(20, 70);
			if (phase_no == 2) begin
				hold_req <= hold_req + 1;
			end
			repeat (n_items) restart_q.push_back($urandom_range(0, 15) == 0);
			n_random += n_items;
			phase_no++;
			drain();
		end

		if (fails == 0) begin
			$display("multi_waveform_generator test passed");
		end else begin
			$display("multi_waveform_generator test failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/mwg_pkg.sv
hdl/mwg_fifo.sv
hdl/mwg_front.sv
hdl/mwg_back.sv
hdl/multi_waveform_generator.sv
dv/multi_waveform_generator_tb.sv
